// ===== design/mmlcd_pkg.sv =====
`timescale 1ns / 1ps

package mmlcd_pkg;

   // Bits in one output word
   localparam int BYTE_BITS = 8;
   localparam int BIT_CNT_W = $clog2(BYTE_BITS);

   // Widest bit group one symbol can produce (a 4B/5B nibble)
   localparam int GROUP_BITS  = 4;
   localparam int GROUP_CNT_W = $clog2(GROUP_BITS + 1);

   // Symbols in a 4B/5B code group
   localparam int CODE5_LEN = 5;
   localparam int CODE5_CNT_W = $clog2(CODE5_LEN);

   // Received symbol codes
   localparam logic [1:0] SYM_ZERO  = 2'd0;
   localparam logic [1:0] SYM_PLUS  = 2'd1;
   localparam logic [1:0] SYM_MINUS = 2'd2;
   localparam logic [1:0] SYM_ONE   = 2'd3;

   typedef enum logic [2:0] {
      LC_NRZL   = 3'd0,
      LC_NRZI   = 3'd1,
      LC_RZ     = 3'd2,
      LC_MANCH  = 3'd3,
      LC_DMANCH = 3'd4,
      LC_AMI    = 3'd5,
      LC_PSEUDO = 3'd6,
      LC_4B5B   = 3'd7
   } line_code_type;

   // Bits decoded from one symbol: first bit at bits[count-1]
   typedef struct packed {
      logic [GROUP_CNT_W-1:0] count;
      logic [GROUP_BITS-1:0]  bits;
   } bit_group_type;

   typedef struct packed {
      logic                  hit;
      logic [GROUP_BITS-1:0] data;
   } code5_dec_type;

   // 4B/5B receive table
   function automatic code5_dec_type decode_code5(input logic [CODE5_LEN-1:0] code);
      code5_dec_type d;
      d.hit  = 1'b1;
      d.data = '0;
      case (code)
         5'b11110: d.data = 4'h0;
         5'b01001: d.data = 4'h1;
         5'b10100: d.data = 4'h2;
         5'b10101: d.data = 4'h3;
         5'b01010: d.data = 4'h4;
         5'b01011: d.data = 4'h5;
         5'b01110: d.data = 4'h6;
         5'b01111: d.data = 4'h7;
         5'b10010: d.data = 4'h8;
         5'b10011: d.data = 4'h9;
         5'b10110: d.data = 4'hA;
         5'b10111: d.data = 4'hB;
         5'b11010: d.data = 4'hC;
         5'b11011: d.data = 4'hD;
         5'b11100: d.data = 4'hE;
         5'b11101: d.data = 4'hF;
         default:  d.hit  = 1'b0;
      endcase
      return d;
   endfunction

endpackage

// ===== design/mmlcd_front.sv =====
`timescale 1ns / 1ps

// Symbol classifier: turns each accepted symbol into a group of 0 to 4 bits.
module mmlcd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  mmlcd_pkg::line_code_type line_code,
   input  logic                   sym_accept,
   input  logic [1:0]             sym,
   output logic                   group_valid,
   output mmlcd_pkg::bit_group_type group_out
);

   logic started_ff, started_in;
   logic prev_level_ff, prev_level_in;
   logic prev_polar_ff, prev_polar_in;
   logic half_phase_ff, half_phase_in;
   logic [mmlcd_pkg::CODE5_LEN-1:0]   group_shift_ff, group_shift_in;
   logic [mmlcd_pkg::CODE5_CNT_W-1:0] group_count_ff, group_count_in;
   logic group_bad_ff, group_bad_in;

   logic polar, lvl, pp, pl, bad_next;
   logic [mmlcd_pkg::CODE5_LEN-1:0] shift_next;
   mmlcd_pkg::code5_dec_type dec;
   mmlcd_pkg::bit_group_type grp;

   // Per-code decode
   always_comb begin
      polar = (sym == mmlcd_pkg::SYM_PLUS) || (sym == mmlcd_pkg::SYM_MINUS);
      lvl   = (sym == mmlcd_pkg::SYM_MINUS);
      pp    = started_ff ? prev_polar_ff : 1'b1;
      pl    = started_ff ? prev_level_ff : 1'b0;
      bad_next   = group_bad_ff | polar;
      shift_next = {group_shift_ff[mmlcd_pkg::CODE5_LEN-2:0], (sym == mmlcd_pkg::SYM_ONE)};
      dec        = mmlcd_pkg::decode_code5(shift_next);

      grp.count = '0;
      grp.bits  = '0;
      prev_level_in  = prev_level_ff;
      prev_polar_in  = prev_polar_ff;
      half_phase_in  = half_phase_ff;
      group_shift_in = group_shift_ff;
      group_count_in = group_count_ff;
      group_bad_in   = group_bad_ff;

      case (line_code)
         mmlcd_pkg::LC_NRZL: begin
            grp.count = mmlcd_pkg::GROUP_CNT_W'(1);
            grp.bits  = {3'b000, lvl};
         end
         mmlcd_pkg::LC_NRZI: begin
            grp.count = mmlcd_pkg::GROUP_CNT_W'(1);
            grp.bits  = {3'b000, ~(polar && pp && (lvl == pl))};
            prev_polar_in = polar;
            prev_level_in = lvl;
         end
         mmlcd_pkg::LC_RZ, mmlcd_pkg::LC_MANCH, mmlcd_pkg::LC_DMANCH: begin
            if (!half_phase_ff) begin
               grp.count = mmlcd_pkg::GROUP_CNT_W'(1);
               case (line_code)
                  mmlcd_pkg::LC_RZ:    grp.bits[0] = (sym == mmlcd_pkg::SYM_PLUS);
                  mmlcd_pkg::LC_MANCH: grp.bits[0] = (sym != mmlcd_pkg::SYM_PLUS);
                  default: begin
                     // differential: first bit stands alone
                     if (!started_ff) grp.bits[0] = (sym != mmlcd_pkg::SYM_MINUS);
                     else grp.bits[0] = polar && prev_polar_ff && (lvl != prev_level_ff);
                     prev_polar_in = polar;
                     prev_level_in = lvl;
                  end
               endcase
               half_phase_in = 1'b1;
            end else begin
               half_phase_in = 1'b0;
            end
         end
         mmlcd_pkg::LC_AMI: begin
            grp.count = mmlcd_pkg::GROUP_CNT_W'(1);
            grp.bits  = {3'b000, polar};
         end
         mmlcd_pkg::LC_PSEUDO: begin
            grp.count = mmlcd_pkg::GROUP_CNT_W'(1);
            grp.bits  = {3'b000, ~polar};
         end
         default: begin
            // 4B/5B: gather five symbols, then look up the group
            if (group_count_ff == mmlcd_pkg::CODE5_CNT_W'(mmlcd_pkg::CODE5_LEN - 1)) begin
               if (!bad_next && dec.hit) begin
                  grp.count = mmlcd_pkg::GROUP_CNT_W'(mmlcd_pkg::GROUP_BITS);
                  grp.bits  = dec.data;
               end
               group_shift_in = '0;
               group_count_in = '0;
               group_bad_in   = 1'b0;
            end else begin
               group_shift_in = shift_next;
               group_count_in = group_count_ff + 1'b1;
               group_bad_in   = bad_next;
            end
         end
      endcase

      started_in  = started_ff | (grp.count != '0);
      group_valid = sym_accept && (grp.count != '0);
      group_out   = grp;
   end

   // Decode state
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff     <= 1'b0;
         prev_level_ff  <= 1'b0;
         prev_polar_ff  <= 1'b0;
         half_phase_ff  <= 1'b0;
         group_shift_ff <= '0;
         group_count_ff <= '0;
         group_bad_ff   <= 1'b0;
      end else if (sym_accept) begin
         started_ff     <= started_in;
         prev_level_ff  <= prev_level_in;
         prev_polar_ff  <= prev_polar_in;
         half_phase_ff  <= half_phase_in;
         group_shift_ff <= group_shift_in;
         group_count_ff <= group_count_in;
         group_bad_ff   <= group_bad_in;
      end
   end

endmodule

// ===== design/mmlcd_queue.sv =====
`timescale 1ns / 1ps

// Small FIFO of bit groups between classifier and packer.
module mmlcd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mmlcd_pkg::bit_group_type push_data,
   output logic                     full,
   input  logic                     pop,
   output logic                     not_empty,
   output mmlcd_pkg::bit_group_type head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   mmlcd_pkg::bit_group_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== design/mmlcd_back.sv =====
`timescale 1ns / 1ps

// Bit packer: shifts bit groups into a byte, MSB first, and holds the output word.
module mmlcd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     group_valid,
   input  mmlcd_pkg::bit_group_type group_in,
   output logic                     group_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [mmlcd_pkg::BYTE_BITS-1:0] rsp_data_byte
);

   logic [mmlcd_pkg::BYTE_BITS-1:0] byte_shift_ff, byte_shift_in;
   logic [mmlcd_pkg::BIT_CNT_W-1:0] bit_count_ff, bit_count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [mmlcd_pkg::BYTE_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                            emit;
   logic [mmlcd_pkg::BYTE_BITS-1:0] emit_byte;

   // Pop when the output slot is free or draining
   assign group_pop = group_valid && (!rsp_valid_ff || rsp_ready);

   // Shift in up to four bits; at most one byte completes
   always_comb begin
      byte_shift_in = byte_shift_ff;
      bit_count_in  = bit_count_ff;
      emit          = 1'b0;
      emit_byte     = byte_shift_ff;
      for (int i = mmlcd_pkg::GROUP_BITS - 1; i >= 0; i--) begin
         if (mmlcd_pkg::GROUP_CNT_W'(i) < group_in.count) begin
            byte_shift_in = {byte_shift_in[mmlcd_pkg::BYTE_BITS-2:0], group_in.bits[i]};
            if (bit_count_in == mmlcd_pkg::BIT_CNT_W'(mmlcd_pkg::BYTE_BITS - 1)) begin
               emit         = 1'b1;
               emit_byte    = byte_shift_in;
               bit_count_in = '0;
            end else begin
               bit_count_in = bit_count_in + 1'b1;
            end
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (group_pop && emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_byte;
      end
   end

   // Packing state and output word
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_shift_ff <= '0;
         bit_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (group_pop) begin
            byte_shift_ff <= byte_shift_in;
            bit_count_ff  <= bit_count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_byte = rsp_data_ff;

endmodule

// ===== design/multi_mode_line_code_decoder.sv =====
`timescale 1ns / 1ps

// Channel   Ports                         Dir   Word
// req       req_valid/req_ready           in    req_symbol[1:0]
// rsp       rsp_valid/rsp_ready           out   rsp_data_byte[7:0]
// csr       csr_valid/csr_ready           in    csr_line_code[2:0]
//
// One symbol is taken per cycle while the queue is not full; a decoded byte
// passes from the classifier through the queue to the output register.
// Reset (synchronous) clears decode state, packer and queue; line code is NRZ-L.
// The classifier stalls only when the queue is full; the packer stalls only
// when a finished byte waits on rsp_ready.
module multi_mode_line_code_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_symbol,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_line_code
);

   mmlcd_pkg::line_code_type line_code_ff;
   logic                     req_accept;
   logic                     q_push, q_full, q_pop, q_not_empty;
   mmlcd_pkg::bit_group_type q_in, q_head;

   // Line code register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) line_code_ff <= mmlcd_pkg::LC_NRZL;
      else if (csr_valid) line_code_ff <= mmlcd_pkg::line_code_type'(csr_line_code);
   end

   assign req_ready  = !q_full;
   assign req_accept = req_valid && req_ready;

   mmlcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .line_code   (line_code_ff),
      .sym_accept  (req_accept),
      .sym         (req_symbol),
      .group_valid (q_push),
      .group_out   (q_in)
   );

   mmlcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   mmlcd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .group_valid   (q_not_empty),
      .group_in      (q_head),
      .group_pop     (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data_byte (rsp_data_byte)
   );

   // Queue never written while full
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("bit group queue overflow");

   // Empty groups are never queued
   assert property (@(posedge clock) disable iff (reset) q_pop |-> (q_head.count != '0))
      else $error("empty bit group reached packer");

   // A group larger than a nibble never leaves the classifier
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_in.count <= 3'(mmlcd_pkg::GROUP_BITS)))
      else $error("bit group count out of range");

   // No word is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

// ===== tb/sv/multi_mode_line_code_decoder_tb.sv =====
`timescale 1ns / 1ps

module multi_mode_line_code_decoder_tb;

   localparam int DRAIN_CYCLES = 10;   // idle cycles after last byte before a csr write
   localparam int LONG_HOLD    = 300;  // receiver back-pressure stretch
   localparam int PHASE_ITEMS  = 50;
   localparam int NUM_PHASES   = 20;
   localparam int MAX_REPORTS  = 10;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_symbol;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_data_byte;
   logic       csr_valid;
   logic       csr_ready;
   logic [2:0] csr_line_code;

   multi_mode_line_code_decoder i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_symbol    (req_symbol),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data_byte (rsp_data_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_line_code (csr_line_code)
   );

   // Directed stimulus row: either a line code write or one symbol word
   typedef struct {
      bit                       is_cfg;
      mmlcd_pkg::line_code_type code;
      logic [1:0]               sym;
      bit                       has_exp;
      logic [7:0]               exp_byte;
   } stim_row_type;

   stim_row_type stim_rows[$];

   // Decoder state mirror
   mmlcd_pkg::line_code_type p_code = mmlcd_pkg::LC_NRZL;
   logic       p_started    = 1'b0;
   logic       p_prev_level = 1'b0;
   logic       p_prev_polar = 1'b0;
   logic       p_half       = 1'b0;
   logic [4:0] p_grp_shift  = '0;
   int         p_grp_cnt    = 0;
   logic       p_grp_bad    = 1'b0;
   logic [7:0] p_byte       = '0;
   int         p_bit_cnt    = 0;
   logic       p_got;
   logic [7:0] p_out;

   logic [7:0] pending_bytes[$];

   // Typed expectation riding along with the current symbol word
   bit         row_has_exp = 1'b0;
   logic [7:0] row_exp     = '0;

   int   symbols_sent   = 0;
   int   bytes_checked  = 0;
   int   mismatch_count = 0;
   int   rsp_gap        = 0;
   int   hold_left      = 0;
   bit   rsp_hold_req   = 1'b0;
   bit   send_burst     = 1'b0;
   bit   rsp_burst      = 1'b0;
   bit   stalled_input  = 1'b0;
   logic [7:0] codes_written = '0;

   // Clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // 4B/5B transmit code for a nibble
   function automatic logic [4:0] code_of_nibble(input logic [3:0] n);
      logic [4:0] c;
      case (n)
         4'h0: c = 5'b11110;
         4'h1: c = 5'b01001;
         4'h2: c = 5'b10100;
         4'h3: c = 5'b10101;
         4'h4: c = 5'b01010;
         4'h5: c = 5'b01011;
         4'h6: c = 5'b01110;
         4'h7: c = 5'b01111;
         4'h8: c = 5'b10010;
         4'h9: c = 5'b10011;
         4'hA: c = 5'b10110;
         4'hB: c = 5'b10111;
         4'hC: c = 5'b11010;
         4'hD: c = 5'b11011;
         4'hE: c = 5'b11100;
         default: c = 5'b11101;
      endcase
      return c;
   endfunction

   // Mostly back-to-back, some short gaps, a few long ones
   function automatic int draw_gap(input bit burst);
      int r;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Shift one decoded bit into the byte packer, MSB first
   task automatic pack_bit(input logic b);
      p_byte    = {p_byte[6:0], b};
      p_started = 1'b1;
      if (p_bit_cnt == 7) begin
         p_got     = 1'b1;
         p_out     = p_byte;
         p_bit_cnt = 0;
      end else begin
         p_bit_cnt++;
      end
   endtask

   // Decode one symbol under the current line code
   task automatic predict_decode(input logic [1:0] sym);
      logic polar;
      logic lvl;
      logic b;
      logic pp;
      logic pl;
      logic [3:0] nib;
      polar = (sym == mmlcd_pkg::SYM_PLUS) || (sym == mmlcd_pkg::SYM_MINUS);
      lvl   = (sym == mmlcd_pkg::SYM_MINUS);
      p_got = 1'b0;
      case (p_code)
         mmlcd_pkg::LC_NRZL: pack_bit(lvl);
         mmlcd_pkg::LC_NRZI: begin
            // before the first bit the previous level counts as plus
            pp = p_started ? p_prev_polar : 1'b1;
            pl = p_started ? p_prev_level : 1'b0;
            b  = !(polar && pp && (lvl == pl));
            p_prev_polar = polar;
            p_prev_level = lvl;
            pack_bit(b);
         end
         mmlcd_pkg::LC_RZ, mmlcd_pkg::LC_MANCH, mmlcd_pkg::LC_DMANCH: begin
            if (!p_half) begin
               if (p_code == mmlcd_pkg::LC_RZ)
                  b = (sym == mmlcd_pkg::SYM_PLUS);
               else if (p_code == mmlcd_pkg::LC_MANCH)
                  b = (sym != mmlcd_pkg::SYM_PLUS);
               else if (!p_started)
                  b = (sym != mmlcd_pkg::SYM_MINUS);
               else
                  b = polar && p_prev_polar && (lvl != p_prev_level);
               if (p_code == mmlcd_pkg::LC_DMANCH) begin
                  p_prev_polar = polar;
                  p_prev_level = lvl;
               end
               p_half = 1'b1;
               pack_bit(b);
            end else begin
               // second half carries no information
               p_half = 1'b0;
            end
         end
         mmlcd_pkg::LC_AMI: pack_bit(polar);
         mmlcd_pkg::LC_PSEUDO: pack_bit(!polar);
         default: begin
            if (polar) p_grp_bad = 1'b1;
            p_grp_shift = {p_grp_shift[3:0], sym == mmlcd_pkg::SYM_ONE};
            p_grp_cnt++;
            if (p_grp_cnt >= 5) begin
               // groups with polar symbols or unknown codes are dropped
               if (!p_grp_bad) begin
                  for (int k = 0; k < 16; k++) begin
                     nib = k[3:0];
                     if (code_of_nibble(nib) == p_grp_shift) begin
                        pack_bit(nib[3]);
                        pack_bit(nib[2]);
                        pack_bit(nib[1]);
                        pack_bit(nib[0]);
                     end
                  end
               end
               p_grp_shift = '0;
               p_grp_cnt   = 0;
               p_grp_bad   = 1'b0;
            end
         end
      endcase
   endtask

   task automatic note_mismatch(input bit have_exp, input logic [7:0] exp_b,
                                input logic [7:0] act_b);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         if (have_exp)
            $display("tb: data_byte mismatch at %0t: expected %02h, got %02h",
                     $realtime, exp_b, act_b);
         else
            $display("tb: unexpected data_byte %02h at %0t", act_b, $realtime);
      end
   endtask

   // Monitor: track csr and symbol words, check output words
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_bytes.size() == 0) begin
               note_mismatch(1'b0, 8'h00, rsp_data_byte);
            end else begin
               if (rsp_data_byte !== pending_bytes[0])
                  note_mismatch(1'b1, pending_bytes[0], rsp_data_byte);
               void'(pending_bytes.pop_front());
            end
            bytes_checked++;
            rsp_gap = draw_gap(rsp_burst);
         end
         if (csr_valid && csr_ready) p_code = mmlcd_pkg::line_code_type'(csr_line_code);
         if (req_valid && req_ready) begin
            predict_decode(req_symbol);
            if (p_got) pending_bytes.push_back(row_has_exp ? row_exp : p_out);
         end
         if (req_valid && !req_ready) stalled_input = 1'b1;
      end
   end

   // Receiver: random stalls plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            hold_left    = LONG_HOLD - 1;
            rsp_ready   <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_ready <= 1'b0;
            rsp_gap--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one symbol word, return once it is taken
   task automatic send_symbol(input logic [1:0] sym, input bit has_exp,
                              input logic [7:0] exp_b);
      int gap;
      gap = draw_gap(send_burst);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_symbol  <= sym;
      row_has_exp <= has_exp;
      row_exp     <= exp_b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      symbols_sent++;
   endtask

   // Let the block drain, then write the line code
   task automatic write_line_code(input mmlcd_pkg::line_code_type code);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid     <= 1'b1;
      csr_line_code <= code;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      codes_written[code] = 1'b1;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One 4B/5B group, first symbol first; bad_pos >= 0 puts a polar symbol there
   task automatic send_group(input logic [4:0] code, input int bad_pos);
      logic [1:0] sym;
      for (int i = 4; i >= 0; i--) begin
         sym = code[i] ? mmlcd_pkg::SYM_ONE : mmlcd_pkg::SYM_ZERO;
         if (i == bad_pos)
            sym = $urandom_range(0, 1) ? mmlcd_pkg::SYM_PLUS : mmlcd_pkg::SYM_MINUS;
         send_symbol(sym, 1'b0, 8'h00);
      end
   endtask

   task automatic run_phase(input mmlcd_pkg::line_code_type code, input int n_items);
      int sent;
      int r;
      write_line_code(code);
      send_burst = ($urandom_range(0, 3) == 0);
      rsp_burst  = ($urandom_range(0, 3) == 0);
      sent = 0;
      if (code == mmlcd_pkg::LC_4B5B) begin
         // finish any group left open by an earlier phase
         if (p_grp_cnt != 0) begin
            for (int i = p_grp_cnt; i < 5; i++) begin
               send_symbol($urandom_range(0, 1) ? mmlcd_pkg::SYM_ONE : mmlcd_pkg::SYM_ZERO,
                           1'b0, 8'h00);
               sent++;
            end
         end
         while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 85)
               send_group(code_of_nibble(4'($urandom_range(0, 15))), -1);
            else if (r < 93)
               send_group(5'($urandom_range(0, 31)), -1);
            else
               send_group(5'($urandom_range(0, 31)), $urandom_range(0, 4));
            sent += 5;
         end
      end else begin
         for (int i = 0; i < n_items; i++)
            send_symbol(2'($urandom_range(0, 3)), 1'b0, 8'h00);
      end
   endtask

   task automatic add_cfg(input mmlcd_pkg::line_code_type code);
      stim_row_type row;
      row.is_cfg   = 1'b1;
      row.code     = code;
      row.sym      = mmlcd_pkg::SYM_ZERO;
      row.has_exp  = 1'b0;
      row.exp_byte = '0;
      stim_rows.push_back(row);
   endtask

   task automatic add_sym(input logic [1:0] sym, input bit has_exp,
                          input logic [7:0] exp_b);
      stim_row_type row;
      row.is_cfg   = 1'b0;
      row.code     = mmlcd_pkg::LC_NRZL;
      row.sym      = sym;
      row.has_exp  = has_exp;
      row.exp_byte = exp_b;
      stim_rows.push_back(row);
   endtask

   // Main sequence
   initial begin
      mmlcd_pkg::line_code_type code;
      int r;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_symbol    = mmlcd_pkg::SYM_ZERO;
      csr_valid     = 1'b0;
      csr_line_code = mmlcd_pkg::LC_NRZL;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: NRZ-I first bit against plus, then every other code but NRZ-L in turn
      add_cfg(mmlcd_pkg::LC_NRZI);
      add_sym(mmlcd_pkg::SYM_PLUS, 1'b0, 8'h00);
      add_sym(mmlcd_pkg::SYM_MINUS, 1'b0, 8'h00);
      add_sym(mmlcd_pkg::SYM_MINUS, 1'b0, 8'h00);
      add_sym(mmlcd_pkg::SYM_ZERO, 1'b0, 8'h00);
      add_cfg(mmlcd_pkg::LC_RZ);
      add_sym(mmlcd_pkg::SYM_PLUS, 1'b0, 8'h00);
      add_sym(mmlcd_pkg::SYM_ZERO, 1'b0, 8'h00);
      // unpaired first half, decided at once
      add_cfg(mmlcd_pkg::LC_MANCH);
      add_sym(mmlcd_pkg::SYM_ZERO, 1'b0, 8'h00);
      // phase carries over: first symbol here is a second half
      add_cfg(mmlcd_pkg::LC_DMANCH);
      add_sym(mmlcd_pkg::SYM_ONE, 1'b0, 8'h00);
      add_sym(mmlcd_pkg::SYM_MINUS, 1'b0, 8'h00);
      add_cfg(mmlcd_pkg::LC_AMI);
      add_sym(mmlcd_pkg::SYM_PLUS, 1'b0, 8'h00);
      // bad group with a polar symbol is dropped, then nibble F
      add_cfg(mmlcd_pkg::LC_4B5B);
      add_sym(mmlcd_pkg::SYM_ONE, 1'b0, 8'h00);
      add_sym(mmlcd_pkg::SYM_PLUS, 1'b0, 8'h00);
      add_sym(mmlcd_pkg::SYM_ONE, 1'b0, 8'h00);
      add_sym(mmlcd_pkg::SYM_ONE, 1'b0, 8'h00);
      add_sym(mmlcd_pkg::SYM_ZERO, 1'b0, 8'h00);
      add_sym(mmlcd_pkg::SYM_ONE, 1'b0, 8'h00);
      add_sym(mmlcd_pkg::SYM_ONE, 1'b0, 8'h00);
      add_sym(mmlcd_pkg::SYM_ONE, 1'b0, 8'h00);
      add_sym(mmlcd_pkg::SYM_ZERO, 1'b0, 8'h00);
      add_sym(mmlcd_pkg::SYM_ONE, 1'b0, 8'h00);
      // four pseudoternary ones complete an all-ones byte
      add_cfg(mmlcd_pkg::LC_PSEUDO);
      add_sym(mmlcd_pkg::SYM_ZERO, 1'b0, 8'h00);
      add_sym(mmlcd_pkg::SYM_ZERO, 1'b0, 8'h00);
      add_sym(mmlcd_pkg::SYM_ZERO, 1'b0, 8'h00);
      add_sym(mmlcd_pkg::SYM_ZERO, 1'b1, 8'hFF);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].is_cfg)
            write_line_code(stim_rows[i].code);
         else
            send_symbol(stim_rows[i].sym, stim_rows[i].has_exp, stim_rows[i].exp_byte);
      end

      // Back-pressure: receiver holds off while symbols keep coming
      write_line_code(mmlcd_pkg::LC_NRZL);
      send_burst   = 1'b1;
      rsp_burst    = 1'b0;
      rsp_hold_req = 1'b1;
      for (int i = 0; i < 120; i++)
         send_symbol(2'($urandom_range(0, 3)), 1'b0, 8'h00);

      // Random phases: every code once, then biased toward the extremes
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph < 8) begin
            code = mmlcd_pkg::line_code_type'(ph[2:0]);
         end else begin
            r = $urandom_range(0, 9);
            if (r < 2)
               code = mmlcd_pkg::LC_NRZL;
            else if (r < 4)
               code = mmlcd_pkg::LC_4B5B;
            else
               code = mmlcd_pkg::line_code_type'(3'($urandom_range(0, 7)));
         end
         run_phase(code, PHASE_ITEMS);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("tb: %0d symbols sent, %0d bytes checked, line codes written mask %08b",
               symbols_sent, bytes_checked, codes_written);
      $display("tb: input stall seen %0d, mismatches %0d", stalled_input, mismatch_count);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/mmlcd_pkg.sv
design/mmlcd_front.sv
design/mmlcd_queue.sv
design/mmlcd_back.sv
design/multi_mode_line_code_decoder.sv
tb/sv/multi_mode_line_code_decoder_tb.sv
